@@ rtl/dnve_pkg.sv @@
// dnve_pkg: shared types and constants for the DNS name validate/encode block.
// Status codes, character constants and the per-item decision struct.
// No dependencies.
package dnve_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_CHAR   = 3'd1,
    ST_HYPHEN     = 3'd2,
    ST_LABEL_LONG = 3'd3,
    ST_NAME_LONG  = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_HYPHEN  = 8'h2D;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  // results one item may carry before a terminator is deferred
  localparam int RESULTS_MAX = 64;
  localparam int RES_W       = 7;

  typedef struct packed {
    logic    fail;       // one error result
    status_t code;
    logic    store;      // write char into label, bump label length
    logic    send;       // emit length byte plus label bytes
    logic    term;       // zero terminator after the burst
    logic    clear;      // reset name state
    logic    drop;       // skip rest of name
    logic    count;      // bump name length
    logic    close;      // label closed by a dot
    logic    mark_sent;  // full label already sent
  } dec_t;

endpackage

@@ rtl/dnve_if.sv @@
// dnve_if: valid/ready channel interfaces for name characters and wire bytes.
// Depends on nothing.
interface dnve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_name;

  modport source (output valid, output character, output end_of_name, input ready);
  modport sink   (input valid, input character, input end_of_name, output ready);
endinterface

interface dnve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       final_res;
  logic [2:0] status;

  modport source (output valid, output wire_byte, output final_res, output status, input ready);
  modport sink   (input valid, input wire_byte, input final_res, input status, output ready);
endinterface

@@ rtl/dnve_ram.sv @@
// dnve_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module dnve_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dnve_check.sv @@
// dnve_check: folds case, classifies one character and decides its action.
// Depends on dnve_pkg.
module dnve_check #(
  parameter int LABEL_MAX = 63,
  parameter int NAME_MAX  = 255,
  localparam int LW = $clog2(LABEL_MAX + 1),
  localparam int NW = $clog2(NAME_MAX + 2)
) (
  input  logic [7:0]      character,
  input  logic            last,
  input  logic [LW-1:0]   len,
  input  logic [NW-1:0]   name_len,
  input  logic            sent,
  input  logic            dropping,
  input  logic            hyph,
  output logic [7:0]      fold,
  output dnve_pkg::dec_t  dec
);
  import dnve_pkg::*;

  logic letter, digit, is_dot, is_hy;

  always_comb begin
    fold = character;
    if (character inside {[8'h41:8'h5A]}) begin
      fold = character + CASE_DELTA;
    end
    letter = fold inside {[8'h61:8'h7A]};
    digit  = fold inside {[8'h30:8'h39]};
    is_dot = (fold == CH_DOT);
    is_hy  = (fold == CH_HYPHEN);
  end

  always_comb begin
    dec = '0;
    dec.code = ST_OK;
    if (dropping) begin
      dec.clear = last;
    end else begin
      dec.count = 1'b1;
      if (name_len >= NW'(NAME_MAX)) begin
        dec.fail = 1'b1;
        dec.code = ST_NAME_LONG;
      end else if (!(letter || digit || is_dot || is_hy)) begin
        dec.fail = 1'b1;
        dec.code = ST_BAD_CHAR;
      end else if (is_dot) begin
        if (len == '0) begin
          dec.fail = 1'b1;
          dec.code = ST_EMPTY;
        end else if (hyph) begin
          dec.fail = 1'b1;
          dec.code = ST_HYPHEN;
        end else begin
          dec.send  = !sent;
          dec.close = 1'b1;
          dec.term  = last;
          dec.clear = last;
        end
      end else if (len == '0 && is_hy) begin
        dec.fail = 1'b1;
        dec.code = ST_HYPHEN;
      end else if (sent || len >= LW'(LABEL_MAX)) begin
        dec.fail = 1'b1;
        dec.code = ST_LABEL_LONG;
      end else begin
        dec.store = 1'b1;
        if (last) begin
          if (is_hy) begin
            dec.fail = 1'b1;
            dec.code = ST_HYPHEN;
          end else begin
            dec.send  = 1'b1;
            dec.term  = 1'b1;
            dec.clear = 1'b1;
          end
        end else if (len == LW'(LABEL_MAX - 1)) begin
          dec.send      = 1'b1;
          dec.mark_sent = 1'b1;
        end
      end
      if (dec.fail) begin
        dec.clear = last;
        dec.drop  = !last;
      end
    end
  end

endmodule

@@ rtl/dns_name_validate_encode.sv @@
// dns_name_validate_encode: top level, DNS name validation and label encoding.
// Depends on dnve_pkg, dnve_if, dnve_ram and dnve_check.
//
// name_ch takes one character of a dotted host name per item, end_of_name
// on the final one. wire_ch gives the encoded name: per label a length byte
// and the lowercase label bytes, then a zero byte with final_res set. An
// error gives a single item with final_res set and a nonzero status; the
// remaining characters of that name are consumed without output.
// A character that causes no output leaves the block ready for the next. Otherwise
// the block accepts it, then produces its output items: a label of L
// characters streams L+1 items from the label RAM at one byte per cycle when
// not stalled (registered read). name_ch.ready is low while they are produced.
// Results go through an output register, so a stalled receiver simply
// holds the block in its emit phase; nothing is lost or repeated. When a
// full 63-character label ends a name, the zero byte is given at the start
// of the next item. Reset (rst, synchronous) empties the output register
// and clears all name state; the label RAM needs no clearing pass.
module dns_name_validate_encode #(
  parameter int LABEL_MAX = 63,
  parameter int NAME_MAX  = 255
) (
  input logic         clk,
  input logic         rst,
  dnve_in_if.sink     name_ch,
  dnve_out_if.source  wire_ch
);
  import dnve_pkg::*;

  localparam int LW = $clog2(LABEL_MAX + 1);
  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int NW = $clog2(NAME_MAX + 2);

  typedef enum logic [2:0] {S_IDLE, S_OWED, S_FAIL, S_LEN, S_BYTES, S_TERM} state_t;

  state_t state;

  logic [LW-1:0]  len;
  logic [NW-1:0]  name_len;
  logic           sent;
  logic           dropping;
  logic           hyph;
  logic           owed;

  logic           p_fail;
  status_t        p_code;
  logic           p_send;
  logic           p_term;
  logic [LW-1:0]  p_cnt;
  logic [AW-1:0]  idx;

  logic           o_valid;
  logic [7:0]     o_byte;
  logic           o_final;
  status_t        o_status;

  logic [7:0]     fold;
  dec_t           dec;
  logic           acc;
  logic           load;
  logic           emit;
  logic [LW-1:0]  send_cnt;
  logic [RES_W-1:0] total;
  logic           term_now;
  logic           last_byte;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  dnve_check #(.LABEL_MAX(LABEL_MAX), .NAME_MAX(NAME_MAX)) u_check (
    .character (name_ch.character),
    .last      (name_ch.end_of_name),
    .len       (len),
    .name_len  (name_len),
    .sent      (sent),
    .dropping  (dropping),
    .hyph      (hyph),
    .fold      (fold),
    .dec       (dec)
  );

  dnve_ram #(.WIDTH(8), .DEPTH(LABEL_MAX)) u_label (
    .clk   (clk),
    .we    (acc && dec.store),
    .waddr (len[AW-1:0]),
    .wdata (fold),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign name_ch.ready     = (state == S_IDLE);
  assign acc               = name_ch.valid && (state == S_IDLE);
  assign load              = !o_valid || wire_ch.ready;
  assign emit              = load && (state inside {S_OWED, S_FAIL, S_LEN, S_BYTES, S_TERM});
  assign wire_ch.valid     = o_valid;
  assign wire_ch.wire_byte = o_byte;
  assign wire_ch.final_res = o_final;
  assign wire_ch.status    = o_status;

  assign send_cnt  = dec.store ? len + LW'(1) : len;
  assign total     = RES_W'(owed) + (dec.send ? RES_W'(send_cnt) + RES_W'(1) : RES_W'(0));
  assign term_now  = dec.term && (total < RES_W'(RESULTS_MAX));
  assign last_byte = (LW'(idx) == p_cnt - LW'(1));

  always_comb begin
    rd_addr = '0;
    if (state == S_BYTES) begin
      rd_addr = (load && !last_byte) ? idx + AW'(1) : idx;
    end
  end

  function automatic state_t after_owed(logic f, logic s, logic t);
    state_t n;
    n = S_IDLE;
    if (f) begin
      n = S_FAIL;
    end else if (s) begin
      n = S_LEN;
    end else if (t) begin
      n = S_TERM;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      o_valid  <= 1'b0;
      owed     <= 1'b0;
      len      <= '0;
      name_len <= '0;
      sent     <= 1'b0;
      dropping <= 1'b0;
      hyph     <= 1'b0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
      end else if (wire_ch.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            p_fail <= dec.fail;
            p_code <= dec.code;
            p_send <= dec.send;
            p_term <= term_now;
            p_cnt  <= send_cnt;
            owed   <= dec.term && !term_now;
            state  <= owed ? S_OWED : after_owed(dec.fail, dec.send, term_now);
            if (dec.clear) begin
              len      <= '0;
              name_len <= '0;
              sent     <= 1'b0;
              dropping <= 1'b0;
            end else begin
              if (dec.count) begin
                name_len <= name_len + NW'(1);
              end
              if (dec.drop) begin
                dropping <= 1'b1;
              end
              if (dec.close) begin
                len  <= '0;
                sent <= 1'b0;
              end
              if (dec.store) begin
                len  <= len + LW'(1);
                hyph <= (fold == CH_HYPHEN);
              end
              if (dec.mark_sent) begin
                sent <= 1'b1;
              end
            end
          end
        end
        S_OWED: begin
          if (load) begin
            o_byte   <= 8'd0;
            o_final  <= 1'b1;
            o_status <= ST_OK;
            state    <= after_owed(p_fail, p_send, p_term);
          end
        end
        S_FAIL: begin
          if (load) begin
            o_byte   <= 8'd0;
            o_final  <= 1'b1;
            o_status <= p_code;
            state    <= S_IDLE;
          end
        end
        S_LEN: begin
          if (load) begin
            o_byte   <= 8'(p_cnt);
            o_final  <= 1'b0;
            o_status <= ST_OK;
            idx      <= '0;
            state    <= S_BYTES;
          end
        end
        S_BYTES: begin
          if (load) begin
            o_byte   <= rd_data;
            o_final  <= 1'b0;
            o_status <= ST_OK;
            if (last_byte) begin
              state <= p_term ? S_TERM : S_IDLE;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        S_TERM: begin
          if (load) begin
            o_byte   <= 8'd0;
            o_final  <= 1'b1;
            o_status <= ST_OK;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(LABEL_MAX))
    else $error("label length past maximum");

  a_name_bound: assert property (@(posedge clk) disable iff (rst)
    !dropping |-> name_len <= NW'(NAME_MAX))
    else $error("name length past maximum while live");

  a_burst_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_LEN || state == S_BYTES) |-> p_cnt != '0)
    else $error("label burst with zero length");

  a_owed_first: assert property (@(posedge clk) disable iff (rst)
    (acc && owed) |=> state == S_OWED)
    else $error("deferred terminator not sent first");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    (acc && dropping && !owed) |=> state == S_IDLE)
    else $error("output while dropping rest of name");
`endif

endmodule
